@@ design/tars_pkg.sv @@
package tars_pkg;

   // default field widths
   localparam int COORD_WIDTH_DEF    = 32;
   localparam int UNIT_FRAC_BITS_DEF = 14;

   // normalized magnitudes lie in [2^(NORM_BITS-1), 2^NORM_BITS)
   localparam int NORM_BITS = 30;

   // entries of the queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TX_POS_X = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TX_POS_Y = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TX_POS_Z = 2'd2;

   // queue status seen by the front
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

@@ design/tars_front.sv @@
module tars_front #(
   parameter int CW = tars_pkg::COORD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [CW-1:0]                  req_vert_a_x,
   input  logic signed [CW-1:0]                  req_vert_a_y,
   input  logic signed [CW-1:0]                  req_vert_a_z,
   input  logic signed [CW-1:0]                  req_vert_b_x,
   input  logic signed [CW-1:0]                  req_vert_b_y,
   input  logic signed [CW-1:0]                  req_vert_b_z,
   input  logic signed [CW-1:0]                  req_vert_c_x,
   input  logic signed [CW-1:0]                  req_vert_c_y,
   input  logic signed [CW-1:0]                  req_vert_c_z,
   input  logic                                  csr_we,
   input  logic [tars_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic signed [CW-1:0]                  csr_wdata,
   input  tars_pkg::q_status_type                q_status,
   output logic                                  push,
   output logic [3*(CW+3)-1:0]                   push_data
);

   localparam int AW = CW + 3;

   logic signed [CW-1:0] tx_ff [3];
   logic                 vld_ff, vld_in;
   logic signed [AW-1:0] aim_ff [3];
   logic signed [AW-1:0] aim_in [3];
   logic signed [CW-1:0] va [3];
   logic signed [CW-1:0] vb [3];
   logic signed [CW-1:0] vc [3];
   logic                 ready;
   logic                 accept;

   assign va[0] = req_vert_a_x;
   assign va[1] = req_vert_a_y;
   assign va[2] = req_vert_a_z;
   assign vb[0] = req_vert_b_x;
   assign vb[1] = req_vert_b_y;
   assign vb[2] = req_vert_b_z;
   assign vc[0] = req_vert_c_x;
   assign vc[1] = req_vert_c_y;
   assign vc[2] = req_vert_c_z;

   // transmitter position registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff[0] <= '0;
         tx_ff[1] <= '0;
         tx_ff[2] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            tars_pkg::REG_TX_POS_X: tx_ff[0] <= csr_wdata;
            tars_pkg::REG_TX_POS_Y: tx_ff[1] <= csr_wdata;
            tars_pkg::REG_TX_POS_Z: tx_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake: hold a transaction only while the queue is full
   assign ready  = !vld_ff || !q_status.full;
   assign busy   = !ready;
   assign accept = start && ready;
   assign push   = vld_ff && !q_status.full;

   always_comb begin
      if (accept) begin
         vld_in = 1'b1;
      end else if (push) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   // aim = a + b + c - 3 * tx, three times centroid minus transmitter
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         aim_in[i] = AW'(va[i]) + AW'(vb[i]) + AW'(vc[i])
                   - (AW'(tx_ff[i]) <<< 1) - AW'(tx_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            aim_ff[i] <= aim_in[i];
         end
      end
   end

   assign push_data = {aim_ff[2], aim_ff[1], aim_ff[0]};

endmodule

@@ design/tars_queue.sv @@
module tars_queue #(
   parameter int W = 105
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [W-1:0]           push_data,
   output tars_pkg::q_status_type q_status,
   output logic                   out_vld,
   output logic [W-1:0]           out_data
);

   localparam int DEPTH = tars_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNW   = $clog2(DEPTH + 1);

   logic [W-1:0]   mem [DEPTH];
   logic [PW-1:0]  wr_ptr_ff;
   logic [PW-1:0]  rd_ptr_ff;
   logic [CNW-1:0] count_ff, count_in;
   logic           vld_ff;
   logic [W-1:0]   data_ff;
   logic           pop;

   assign q_status.full  = (count_ff == CNW'(DEPTH));
   assign q_status.empty = (count_ff == '0);

   // back side never stalls, so drain every cycle there is an entry
   assign pop = !q_status.empty;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         vld_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         vld_ff   <= pop;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
      end
   end

   // storage and registered read
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (pop) begin
         data_ff <= mem[rd_ptr_ff];
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;

endmodule

@@ design/tars_norm.sv @@
module tars_norm #(
   parameter int IW  = 34,
   parameter int F   = tars_pkg::UNIT_FRAC_BITS_DEF,
   parameter int SDW = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  logic signed [IW:0]   in_vec [3],
   input  logic [SDW-1:0]       in_side,
   output logic                 out_vld,
   output logic signed [F+1:0]  out_u [3],
   output logic                 out_ok,
   output logic [SDW-1:0]       out_side
);

   localparam int NT  = tars_pkg::NORM_BITS;
   localparam int EW  = (IW > NT) ? IW : NT;
   localparam int SHW = $clog2(EW);
   localparam int SQW = 2 * NT + 2;
   localparam int RW  = NT + 1;
   localparam int DW  = RW + F;
   localparam int QW  = F + 1;
   localparam int UW  = F + 2;

   // stage 1: magnitudes
   logic              v1_ff;
   logic [IW-1:0]     m1_ff [3];
   logic [IW-1:0]     m1_in [3];
   logic [2:0]        n1_ff;
   logic [SDW-1:0]    sd1_ff;
   logic signed [IW:0] negv [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         negv[i]  = -in_vec[i];
         m1_in[i] = in_vec[i][IW] ? negv[i][IW-1:0] : in_vec[i][IW-1:0];
      end
   end

   // stage 2: largest magnitude
   logic              v2_ff;
   logic [IW-1:0]     m2_ff [3];
   logic [IW-1:0]     mx2_ff, mx_in;
   logic [2:0]        n2_ff;
   logic [SDW-1:0]    sd2_ff;

   always_comb begin
      mx_in = m1_ff[0];
      if (m1_ff[1] > mx_in) begin
         mx_in = m1_ff[1];
      end
      if (m1_ff[2] > mx_in) begin
         mx_in = m1_ff[2];
      end
   end

   // stage 3: leading one and common shift amount
   logic              v3_ff;
   logic [IW-1:0]     m3_ff [3];
   logic [2:0]        n3_ff;
   logic [SDW-1:0]    sd3_ff;
   logic [SHW-1:0]    amt3_ff, amt_in, pos;
   logic              rgt3_ff, rgt_in;
   logic              nz3_ff, nz_in;

   always_comb begin
      pos = '0;
      for (int b = 0; b < IW; b++) begin
         if (mx2_ff[b]) begin
            pos = SHW'(b);
         end
      end
      nz_in  = |mx2_ff;
      rgt_in = (pos > SHW'(NT - 1));
      amt_in = rgt_in ? (pos - SHW'(NT - 1)) : (SHW'(NT - 1) - pos);
   end

   // stage 4: shift all three by the same amount
   logic              v4_ff;
   logic [NT-1:0]     m4_ff [3];
   logic [NT-1:0]     m4_in [3];
   logic [EW-1:0]     ext [3];
   logic [EW-1:0]     sh [3];
   logic [2:0]        n4_ff;
   logic [SDW-1:0]    sd4_ff;
   logic              ok4_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ext[i]   = EW'(m3_ff[i]);
         sh[i]    = rgt3_ff ? (ext[i] >> amt3_ff) : (ext[i] << amt3_ff);
         m4_in[i] = sh[i][NT-1:0];
      end
   end

   // stage 5: squares
   logic              v5_ff;
   logic [NT-1:0]     m5_ff [3];
   logic [2*NT-1:0]   sq5_ff [3];
   logic [2:0]        n5_ff;
   logic [SDW-1:0]    sd5_ff;
   logic              ok5_ff;

   // square root pipeline, entry 0 holds the sum of squares
   logic              sv_ff  [RW+1];
   logic [SQW-1:0]    rem_ff [RW+1];
   logic [RW-1:0]     root_ff [RW+1];
   logic [NT-1:0]     sm_ff  [RW+1][3];
   logic [2:0]        sn_ff  [RW+1];
   logic              sok_ff [RW+1];
   logic [SDW-1:0]    ssd_ff [RW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         v5_ff     <= 1'b0;
         sv_ff[0]  <= 1'b0;
      end else begin
         v1_ff     <= in_vld;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         v5_ff     <= v4_ff;
         sv_ff[0]  <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         m1_ff[i]    <= m1_in[i];
         n1_ff[i]    <= in_vec[i][IW];
         m2_ff[i]    <= m1_ff[i];
         m3_ff[i]    <= m2_ff[i];
         m4_ff[i]    <= m4_in[i];
         m5_ff[i]    <= m4_ff[i];
         sq5_ff[i]   <= m4_ff[i] * m4_ff[i];
         sm_ff[0][i] <= m5_ff[i];
      end
      sd1_ff     <= in_side;
      n2_ff      <= n1_ff;
      sd2_ff     <= sd1_ff;
      mx2_ff     <= mx_in;
      n3_ff      <= n2_ff;
      sd3_ff     <= sd2_ff;
      amt3_ff    <= amt_in;
      rgt3_ff    <= rgt_in;
      nz3_ff     <= nz_in;
      n4_ff      <= n3_ff;
      sd4_ff     <= sd3_ff;
      ok4_ff     <= nz3_ff;
      n5_ff      <= n4_ff;
      sd5_ff     <= sd4_ff;
      ok5_ff     <= ok4_ff;
      rem_ff[0]  <= SQW'(sq5_ff[0]) + SQW'(sq5_ff[1]) + SQW'(sq5_ff[2]);
      root_ff[0] <= '0;
      sn_ff[0]   <= n5_ff;
      sok_ff[0]  <= ok5_ff;
      ssd_ff[0]  <= sd5_ff;
   end

   // one root bit per stage, most significant first
   for (genvar j = 0; j < RW; j++) begin : g_sqrt
      localparam int K = RW - 1 - j;
      logic [SQW:0] trial;

      always_comb begin
         trial = ((SQW+1)'(root_ff[j]) << (K + 1)) + ((SQW+1)'(1) << (2 * K));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[j+1] <= 1'b0;
         end else begin
            sv_ff[j+1] <= sv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if ({1'b0, rem_ff[j]} >= trial) begin
            rem_ff[j+1]  <= rem_ff[j] - trial[SQW-1:0];
            root_ff[j+1] <= root_ff[j] | (RW'(1) << K);
         end else begin
            rem_ff[j+1]  <= rem_ff[j];
            root_ff[j+1] <= root_ff[j];
         end
         sm_ff[j+1]  <= sm_ff[j];
         sn_ff[j+1]  <= sn_ff[j];
         sok_ff[j+1] <= sok_ff[j];
         ssd_ff[j+1] <= ssd_ff[j];
      end
   end

   // division pipeline, entry 0 holds the rounded numerators
   logic              dv_ff  [QW+1];
   logic [DW-1:0]     num_ff [QW+1][3];
   logic [QW-1:0]     q_ff   [QW+1][3];
   logic [RW-1:0]     dr_ff  [QW+1];
   logic [2:0]        dn_ff  [QW+1];
   logic              dok_ff [QW+1];
   logic [SDW-1:0]    dsd_ff [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= sv_ff[RW];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         num_ff[0][i] <= (DW'(sm_ff[RW][i]) << F) + DW'(root_ff[RW] >> 1);
         q_ff[0][i]   <= '0;
      end
      dr_ff[0]  <= root_ff[RW];
      dn_ff[0]  <= sn_ff[RW];
      dok_ff[0] <= sok_ff[RW];
      dsd_ff[0] <= ssd_ff[RW];
   end

   // one quotient bit per stage, most significant first
   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int B = F - j;
      logic [DW-1:0] sub;

      always_comb begin
         sub = DW'(dr_ff[j]) << B;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else begin
            dv_ff[j+1] <= dv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         for (int i = 0; i < 3; i++) begin
            if (num_ff[j][i] >= sub) begin
               num_ff[j+1][i] <= num_ff[j][i] - sub;
               q_ff[j+1][i]   <= q_ff[j][i] | (QW'(1) << B);
            end else begin
               num_ff[j+1][i] <= num_ff[j][i];
               q_ff[j+1][i]   <= q_ff[j][i];
            end
         end
         dr_ff[j+1]  <= dr_ff[j];
         dn_ff[j+1]  <= dn_ff[j];
         dok_ff[j+1] <= dok_ff[j];
         dsd_ff[j+1] <= dsd_ff[j];
      end
   end

   // saturate, apply sign, zero on a zero-length vector
   logic              vo_ff;
   logic signed [UW-1:0] u_ff [3];
   logic signed [UW-1:0] u_in [3];
   logic [QW-1:0]     qs [3];
   logic              ok_ff;
   logic [SDW-1:0]    sdo_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qs[i] = (q_ff[QW][i] > (QW'(1) << F)) ? (QW'(1) << F) : q_ff[QW][i];
         if (!dok_ff[QW]) begin
            u_in[i] = '0;
         end else if (dn_ff[QW][i]) begin
            u_in[i] = -UW'(qs[i]);
         end else begin
            u_in[i] = UW'(qs[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= dv_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         u_ff[i] <= u_in[i];
      end
      ok_ff  <= dok_ff[QW];
      sdo_ff <= dsd_ff[QW];
   end

   assign out_vld  = vo_ff;
   assign out_u    = u_ff;
   assign out_ok   = ok_ff;
   assign out_side = sdo_ff;

endmodule

@@ design/tars_back.sv @@
module tars_back #(
   parameter int CW = tars_pkg::COORD_WIDTH_DEF,
   parameter int F  = tars_pkg::UNIT_FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  logic [3*(CW+3)-1:0] in_data,
   output logic                rsp_valid,
   output logic signed [F+1:0] rsp_dir_x,
   output logic signed [F+1:0] rsp_dir_y,
   output logic signed [F+1:0] rsp_dir_z,
   output logic signed [F+1:0] rsp_pol_x,
   output logic signed [F+1:0] rsp_pol_y,
   output logic signed [F+1:0] rsp_pol_z,
   output logic                rsp_degenerate
);

   localparam int AW  = CW + 3;
   localparam int UW  = F + 2;
   localparam int PW  = 2 * UW;
   localparam int VW  = PW + 1;
   localparam int SDW = 3 * UW + 1;

   logic signed [AW-1:0] aim [3];
   logic                 n1_vld;
   logic signed [UW-1:0] d [3];
   logic                 n1_ok;
   logic [0:0]           n1_side;

   assign aim[0] = in_data[0*AW +: AW];
   assign aim[1] = in_data[1*AW +: AW];
   assign aim[2] = in_data[2*AW +: AW];

   // aim direction
   tars_norm #(.IW(AW - 1), .F(F), .SDW(1)) u_norm_dir (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (in_vld),
      .in_vec   (aim),
      .in_side  (1'b0),
      .out_vld  (n1_vld),
      .out_u    (d),
      .out_ok   (n1_ok),
      .out_side (n1_side)
   );

   // products of the quantized direction
   logic                 va_ff;
   logic signed [PW-1:0] pxz_ff, pyz_ff, pxx_ff, pyy_ff;
   logic signed [UW-1:0] da_ff [3];
   logic                 dga_ff;

   // vertical vector (-dx*dz, -dy*dz, dx*dx + dy*dy)
   logic                 vb_ff;
   logic signed [VW-1:0] v_ff [3];
   logic signed [UW-1:0] db_ff [3];
   logic                 dgb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= n1_vld;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      pxz_ff <= d[0] * d[2];
      pyz_ff <= d[1] * d[2];
      pxx_ff <= d[0] * d[0];
      pyy_ff <= d[1] * d[1];
      da_ff  <= d;
      dga_ff <= n1_side[0] | !n1_ok;
      v_ff[0] <= -VW'(pxz_ff);
      v_ff[1] <= -VW'(pyz_ff);
      v_ff[2] <= VW'(pxx_ff) + VW'(pyy_ff);
      db_ff  <= da_ff;
      dgb_ff <= dga_ff;
   end

   // polarization, direction rides along
   logic                 n2_vld;
   logic signed [UW-1:0] p [3];
   logic                 n2_ok;
   logic [SDW-1:0]       side_in, n2_side;
   logic                 deg;

   assign side_in = {dgb_ff, db_ff[2], db_ff[1], db_ff[0]};

   tars_norm #(.IW(PW), .F(F), .SDW(SDW)) u_norm_pol (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (vb_ff),
      .in_vec   (v_ff),
      .in_side  (side_in),
      .out_vld  (n2_vld),
      .out_u    (p),
      .out_ok   (n2_ok),
      .out_side (n2_side)
   );

   // zero every vector when either stage was degenerate
   assign deg            = n2_side[SDW-1] | !n2_ok;
   assign rsp_valid      = n2_vld;
   assign rsp_degenerate = deg;
   assign rsp_dir_x      = deg ? '0 : n2_side[0*UW +: UW];
   assign rsp_dir_y      = deg ? '0 : n2_side[1*UW +: UW];
   assign rsp_dir_z      = deg ? '0 : n2_side[2*UW +: UW];
   assign rsp_pol_x      = deg ? '0 : p[0];
   assign rsp_pol_y      = deg ? '0 : p[1];
   assign rsp_pol_z      = deg ? '0 : p[2];

endmodule

@@ design/triangle_aimed_ray_setup_core.sv @@
// Aims a ray from the transmitter position (csr registers 0..2) at the centroid of
// each triangle and returns the unit direction and the unit vertical polarization,
// or zero vectors with rsp_degenerate set when either vector has zero length. One
// transaction is taken per cycle while start is high and busy is low; each result
// appears for exactly one cycle with rsp_valid and cannot be held off, in the same
// order as the transactions. The two normalizer pipelines each have a 31-stage
// square root and a UNIT_FRAC_BITS+1 stage divider. Write the csr registers only
// while idle.
module triangle_aimed_ray_setup_core #(
   parameter int COORD_WIDTH    = tars_pkg::COORD_WIDTH_DEF,
   parameter int UNIT_FRAC_BITS = tars_pkg::UNIT_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_WIDTH-1:0]        req_vert_a_x,
   input  logic signed [COORD_WIDTH-1:0]        req_vert_a_y,
   input  logic signed [COORD_WIDTH-1:0]        req_vert_a_z,
   input  logic signed [COORD_WIDTH-1:0]        req_vert_b_x,
   input  logic signed [COORD_WIDTH-1:0]        req_vert_b_y,
   input  logic signed [COORD_WIDTH-1:0]        req_vert_b_z,
   input  logic signed [COORD_WIDTH-1:0]        req_vert_c_x,
   input  logic signed [COORD_WIDTH-1:0]        req_vert_c_y,
   input  logic signed [COORD_WIDTH-1:0]        req_vert_c_z,
   input  logic                                 csr_we,
   input  logic [tars_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic signed [COORD_WIDTH-1:0]        csr_wdata,
   output logic                                 rsp_valid,
   output logic signed [UNIT_FRAC_BITS+1:0]     rsp_dir_x,
   output logic signed [UNIT_FRAC_BITS+1:0]     rsp_dir_y,
   output logic signed [UNIT_FRAC_BITS+1:0]     rsp_dir_z,
   output logic signed [UNIT_FRAC_BITS+1:0]     rsp_pol_x,
   output logic signed [UNIT_FRAC_BITS+1:0]     rsp_pol_y,
   output logic signed [UNIT_FRAC_BITS+1:0]     rsp_pol_z,
   output logic                                 rsp_degenerate
);

   localparam int QW = 3 * (COORD_WIDTH + 3);

   tars_pkg::q_status_type q_status;
   logic                   push;
   logic [QW-1:0]          push_data;
   logic                   q_vld;
   logic [QW-1:0]          q_data;

   // front: accept and form the aim vector
   tars_front #(.CW(COORD_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_vert_a_x (req_vert_a_x),
      .req_vert_a_y (req_vert_a_y),
      .req_vert_a_z (req_vert_a_z),
      .req_vert_b_x (req_vert_b_x),
      .req_vert_b_y (req_vert_b_y),
      .req_vert_b_z (req_vert_b_z),
      .req_vert_c_x (req_vert_c_x),
      .req_vert_c_y (req_vert_c_y),
      .req_vert_c_z (req_vert_c_z),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_status     (q_status),
      .push         (push),
      .push_data    (push_data)
   );

   // queue between front and back
   tars_queue #(.W(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .q_status  (q_status),
      .out_vld   (q_vld),
      .out_data  (q_data)
   );

   // back: both normalizations
   tars_back #(.CW(COORD_WIDTH), .F(UNIT_FRAC_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .in_vld         (q_vld),
      .in_data        (q_data),
      .rsp_valid      (rsp_valid),
      .rsp_dir_x      (rsp_dir_x),
      .rsp_dir_y      (rsp_dir_y),
      .rsp_dir_z      (rsp_dir_z),
      .rsp_pol_x      (rsp_pol_x),
      .rsp_pol_y      (rsp_pol_y),
      .rsp_pol_z      (rsp_pol_z),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int CW = 32;
   localparam int UF = 14;
   localparam int UW = UF + 2;
   localparam int LATENCY = 2 * UF + 85;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [tars_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

   typedef struct {
      logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
   } triangle_type;

   typedef struct {
      logic signed [UW-1:0] dx, dy, dz, px, py, pz;
      logic                 degen;
   } ray_setup_type;

   typedef struct {
      longint x, y, z;
   } vec_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [CW-1:0] req_vert_a_x = 0, req_vert_a_y = 0, req_vert_a_z = 0;
   logic signed [CW-1:0] req_vert_b_x = 0, req_vert_b_y = 0, req_vert_b_z = 0;
   logic signed [CW-1:0] req_vert_c_x = 0, req_vert_c_y = 0, req_vert_c_z = 0;
   logic                                 csr_we = 0;
   logic [tars_pkg::CSR_INDEX_WIDTH-1:0] csr_index = tars_pkg::REG_TX_POS_X;
   logic signed [CW-1:0]                 csr_wdata = 0;
   logic                 rsp_valid;
   logic signed [UW-1:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic signed [UW-1:0] rsp_pol_x, rsp_pol_y, rsp_pol_z;
   logic                 rsp_degenerate;

   // transmitter position as the bench sees it
   logic signed [CW-1:0] tx_x = 0, tx_y = 0, tx_z = 0;

   triangle_type  pending_tris[$];
   ray_setup_type expected_rays[$];
   bit            failed = 0;
   bit            calm = 0;
   int            cycles = 0;

   triangle_aimed_ray_setup_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_vert_a_x(req_vert_a_x), .req_vert_a_y(req_vert_a_y),
      .req_vert_a_z(req_vert_a_z), .req_vert_b_x(req_vert_b_x),
      .req_vert_b_y(req_vert_b_y), .req_vert_b_z(req_vert_b_z),
      .req_vert_c_x(req_vert_c_x), .req_vert_c_y(req_vert_c_y),
      .req_vert_c_z(req_vert_c_z),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_dir_x(rsp_dir_x), .rsp_dir_y(rsp_dir_y), .rsp_dir_z(rsp_dir_z),
      .rsp_pol_x(rsp_pol_x), .rsp_pol_y(rsp_pol_y), .rsp_pol_z(rsp_pol_z),
      .rsp_degenerate(rsp_degenerate)
   );

   always #2 clock = ~clock;

   // integer square root, floor
   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // scale a vector to unit length in q1.14, returns 0 for a zero vector
   function automatic bit unit_vector(input vec_type v, output vec_type u);
      logic [63:0] m[3], mx, n2, r, q;
      longint      s[3];
      s[0] = v.x; s[1] = v.y; s[2] = v.z;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = s[i] < 0 ? -s[i] : s[i];
         if (m[i] > mx) mx = m[i];
      end
      u = '{0, 0, 0};
      if (mx == 0) return 0;
      while (mx >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
         mx = mx >> 1;
      end
      while (mx < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
         mx = mx << 1;
      end
      n2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      r = int_sqrt(n2);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << UF) + (r >> 1)) / r;
         if (q > (64'd1 << UF)) q = 64'd1 << UF;
         s[i] = s[i] < 0 ? -longint'(q) : longint'(q);
      end
      u.x = s[0]; u.y = s[1]; u.z = s[2];
      return 1;
   endfunction

   // aim at the centroid (times three) and derive the vertical polarization
   function automatic ray_setup_type aim_ray(input triangle_type t);
      vec_type       aim, d, v, p;
      bit            ok;
      ray_setup_type r;
      aim.x = longint'(t.ax) + longint'(t.bx) + longint'(t.cx) - 3 * longint'(tx_x);
      aim.y = longint'(t.ay) + longint'(t.by) + longint'(t.cy) - 3 * longint'(tx_y);
      aim.z = longint'(t.az) + longint'(t.bz) + longint'(t.cz) - 3 * longint'(tx_z);
      ok = unit_vector(aim, d);
      if (ok) begin
         v.x = -(d.x * d.z);
         v.y = -(d.y * d.z);
         v.z = d.x * d.x + d.y * d.y;
         ok = unit_vector(v, p);
      end
      if (!ok) begin
         d = '{0, 0, 0};
         p = '{0, 0, 0};
      end
      r.dx = d.x[UW-1:0]; r.dy = d.y[UW-1:0]; r.dz = d.z[UW-1:0];
      r.px = p.x[UW-1:0]; r.py = p.y[UW-1:0]; r.pz = p.z[UW-1:0];
      r.degen = !ok;
      return r;
   endfunction

   // coordinate of random magnitude, full range a quarter of the time
   function automatic logic signed [CW-1:0] rand_coord();
      logic signed [CW-1:0] c;
      int k;
      if ($urandom_range(0, 3) == 0) return $urandom;
      k = $urandom_range(1, 31);
      c = $urandom >> (32 - k);
      if ($urandom_range(0, 1)) c = -c;
      return c;
   endfunction

   function automatic triangle_type make_tri(input logic signed [CW-1:0] ax, ay, az,
                                             bx, by, bz, cx, cy, cz);
      triangle_type t;
      t.ax = ax; t.ay = ay; t.az = az;
      t.bx = bx; t.by = by; t.bz = bz;
      t.cx = cx; t.cy = cy; t.cz = cz;
      return t;
   endfunction

   // compact triangle around a random center, sometimes straight above or below the tx, sometimes fully random
   function automatic triangle_type rand_tri();
      triangle_type t;
      logic signed [CW-1:0] ox, oy, oz;
      int sel, spread;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         return make_tri($urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
      end
      ox = rand_coord() >>> 2; oy = rand_coord() >>> 2; oz = rand_coord() >>> 2;
      if (sel == 1) begin
         ox = tx_x; oy = tx_y;
      end
      spread = $urandom_range(0, 20);
      t.ax = ox + ($signed($urandom) >>> (31 - spread));
      t.ay = oy + ($signed($urandom) >>> (31 - spread));
      t.az = oz + ($signed($urandom) >>> (31 - spread));
      t.bx = ox + ($signed($urandom) >>> (31 - spread));
      t.by = oy + ($signed($urandom) >>> (31 - spread));
      t.bz = oz + ($signed($urandom) >>> (31 - spread));
      t.cx = ox + ($signed($urandom) >>> (31 - spread));
      t.cy = oy + ($signed($urandom) >>> (31 - spread));
      t.cz = oz + ($signed($urandom) >>> (31 - spread));
      return t;
   endfunction

   // driver: count the accepted transaction, then present the next one
   always @(posedge clock) begin
      triangle_type t;
      cycles <= cycles + 1;
      if (start && !busy) begin
         t = make_tri(req_vert_a_x, req_vert_a_y, req_vert_a_z, req_vert_b_x,
                      req_vert_b_y, req_vert_b_z, req_vert_c_x, req_vert_c_y,
                      req_vert_c_z);
         expected_rays.push_back(aim_ray(t));
      end
      if (!start || !busy) begin
         if (!reset && pending_tris.size() > 0 && (calm || $urandom_range(0, 99) >= 17))
         begin
            t = pending_tris.pop_front();
            start <= 1;
            req_vert_a_x <= t.ax; req_vert_a_y <= t.ay; req_vert_a_z <= t.az;
            req_vert_b_x <= t.bx; req_vert_b_y <= t.by; req_vert_b_z <= t.bz;
            req_vert_c_x <= t.cx; req_vert_c_y <= t.cy; req_vert_c_z <= t.cz;
         end else begin
            start <= 0;
         end
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      ray_setup_type e;
      if (!reset && rsp_valid) begin
         if (expected_rays.size() == 0) begin
            $display("%0t: unexpected result dir %0d %0d %0d pol %0d %0d %0d degen %0b",
                     $time, rsp_dir_x, rsp_dir_y, rsp_dir_z, rsp_pol_x, rsp_pol_y,
                     rsp_pol_z, rsp_degenerate);
            failed <= 1;
         end else begin
            e = expected_rays.pop_front();
            if (e.dx !== rsp_dir_x || e.dy !== rsp_dir_y || e.dz !== rsp_dir_z ||
                e.px !== rsp_pol_x || e.py !== rsp_pol_y || e.pz !== rsp_pol_z ||
                e.degen !== rsp_degenerate) begin
               $display("%0t: mismatch expected dir %0d %0d %0d pol %0d %0d %0d degen %0b",
                        $time, e.dx, e.dy, e.dz, e.px, e.py, e.pz, e.degen);
               $display("%0t:          actual   dir %0d %0d %0d pol %0d %0d %0d degen %0b",
                        $time, rsp_dir_x, rsp_dir_y, rsp_dir_z, rsp_pol_x, rsp_pol_y,
                        rsp_pol_z, rsp_degenerate);
               failed <= 1;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_csr(input logic [tars_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic signed [CW-1:0] data);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         tars_pkg::REG_TX_POS_X: tx_x = data;
         tars_pkg::REG_TX_POS_Y: tx_y = data;
         tars_pkg::REG_TX_POS_Z: tx_z = data;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_tris.size() != 0 || start || expected_rays.size() != 0);
   endtask

   task automatic set_tx(input logic signed [CW-1:0] x, y, z);
      write_csr(tars_pkg::REG_TX_POS_X, x);
      write_csr(tars_pkg::REG_TX_POS_Y, y);
      write_csr(tars_pkg::REG_TX_POS_Z, z);
   endtask

   localparam logic signed [CW-1:0] MAXC = 32'sh7fffffff;
   localparam logic signed [CW-1:0] MINC = 32'sh80000000;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed triangles with tx at the origin
      pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_tris.push_back(make_tri(0, 0, 5, 0, 0, 7, 0, 0, 9));
      pending_tris.push_back(make_tri(0, 0, -5, 0, 0, -7, 0, 0, -1));
      pending_tris.push_back(make_tri(1, 0, MAXC, 0, 0, MAXC, 0, 0, MAXC));
      pending_tris.push_back(make_tri(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
                                      MAXC, MAXC, MAXC));
      pending_tris.push_back(make_tri(MINC, MINC, MINC, MINC, MINC, MINC,
                                      MINC, MINC, MINC));
      pending_tris.push_back(make_tri(MAXC, MINC, 0, MAXC, MINC, 0, MAXC, MINC, 0));
      pending_tris.push_back(make_tri(1, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_tris.push_back(make_tri(0, -1, 0, 0, 0, 0, 0, 0, 0));
      pending_tris.push_back(make_tri(0, 0, 1, 0, 0, 0, 0, 0, 0));
      pending_tris.push_back(make_tri(1, 1, 1, 0, 0, 0, 0, 0, 0));
      pending_tris.push_back(make_tri(-1, 2, -3, 4, -5, 6, -7, 8, -9));
      pending_tris.push_back(make_tri(MINC, 0, 0, MINC, 0, 0, 1, 0, 0));
      pending_tris.push_back(make_tri(256, 512, 768, -256, 1024, 0, 0, 0, 256));
      wait_drained();

      // extremes of the transmitter position, then random ones
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_tx(0, 0, 0);
            1: set_tx(MAXC, MAXC, MAXC);
            2: set_tx(MINC, MINC, MINC);
            3: set_tx(MAXC, MINC, 0);
            default: set_tx(rand_coord(), rand_coord(), rand_coord());
         endcase
         // the unused index must leave the position alone
         write_csr(REG_UNUSED, $urandom);
         if (phase == 1) begin
            pending_tris.push_back(make_tri(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
                                            MAXC, MAXC, MAXC));
            pending_tris.push_back(make_tri(MAXC, MAXC, 0, MAXC, MAXC, 0,
                                            MAXC, MAXC, 0));
         end
         if (phase == 2) begin
            pending_tris.push_back(make_tri(MINC, MINC, MINC, MINC, MINC, MINC,
                                            MINC, MINC, MINC));
            pending_tris.push_back(make_tri(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
                                            MAXC, MAXC, MAXC));
         end
         calm = (phase == 3);
         for (int i = 0; i < 158; i++) pending_tris.push_back(rand_tri());
         wait_drained();
         calm = 0;
      end

      repeat (LATENCY + 20) @(posedge clock);
      if (!failed) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
